// ===== hdl/gept_pkg.sv =====
// Shared types, constants and helpers of the graph edge property tracker.
`default_nettype none

package gept_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W       = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);
  localparam int VCNT_W       = 8;
  localparam int ISO_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [VCNT_W-1:0] VCOUNT_RST = VCNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT  = 2'd0,
    CFG_DIRECTED_MODE = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RREAD,
    S_RMOD,
    S_DONE
  } state_e;

  // counter changes produced by one read-modify-write pass
  typedef struct packed {
    logic offdiag_inc;
    logic nonzero_inc;
    logic full_inc;
    logic full_dec;
  } cnt_delta_t;

  // store access: rd_a reads row and degree, rd_b reads a second degree
  typedef struct packed {
    logic                    rd_en;
    logic [VTX_W-1:0]        rd_a;
    logic [VTX_W-1:0]        rd_b;
    logic                    wr_en;
    logic [VTX_W-1:0]        wr_addr;
    logic [MAX_VERTICES-1:0] wr_row;
  } store_req_t;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  nonzero;
    logic [EDGE_W-1:0] offdiag;
    logic [CNT_W-1:0]  full;
    logic              loop_seen;
  } result_t;

  // vertex count in use: zero acts as one, large values clamp
  function automatic logic [CNT_W-1:0] active_n(input logic [VCNT_W-1:0] vc);
    logic [CNT_W-1:0] n;
    if (vc == '0) begin
      n = CNT_W'(1);
    end else if (int'(vc) > MAX_VERTICES) begin
      n = CNT_W'(MAX_VERTICES);
    end else begin
      n = CNT_W'(vc);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/graph_edge_property_tracker_unit.sv =====
// Top level of the graph edge property tracker.
//
//  channel  | direction | word
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tdata: src_vertex[6:0], dst_vertex[13:7]
//  m_axis   | out       | tdata: status[1:0], isolated_count[9:2], self_loop_seen[10],
//           |           |        complete_by_matrix[11], complete_by_degree[12]
//  cfg      | in        | cfg_index_i 0 vertex_count, 1 directed_mode; cfg_data_i value
//
//  After acceptance an edge goes through the check state, then the done state when
//  directed or rejected; an undirected edge adds a reverse read and write before done.
//  Each pass is a read then a write of the adjacency row memory through the one shared
//  update unit. The result sits in an output register once the sequencer is done; a
//  stalled result holds the sequencer before the next acceptance. Reset and a write to
//  vertex_count or directed_mode empty the graph at once via per-row valid bits.
`default_nettype none

module graph_edge_property_tracker_unit import gept_pkg::*; #(
  parameter int MAX_LIST_DEGREE = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // src_vertex, dst_vertex, pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // status, isolated_count,
                                                 // self_loop_seen, complete_by_matrix,
                                                 // complete_by_degree, pad
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DEG_W = $clog2(MAX_LIST_DEGREE + 1);

  logic [VCNT_W-1:0] vcount_q, vcount_d;
  logic              directed_q, directed_d;
  logic              cfg_wr, clear;
  logic [CNT_W-1:0]  n, n_next;

  logic                    res_valid;
  result_t                 res;
  store_req_t              req;
  logic [DEG_W-1:0]        wr_deg;
  logic [MAX_VERTICES-1:0] row;
  logic [DEG_W-1:0]        deg_a, deg_b;

  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic                   out_free;
  logic [ISO_W-1:0]       iso;
  logic [2*CNT_W-1:0]     pairs;
  logic                   cbm, cbd;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    vcount_d   = vcount_q;
    directed_d = directed_q;
    clear      = 1'b0;
    if (cfg_wr) begin
      if (cfg_index_i == CFG_VERTEX_COUNT) begin
        vcount_d = cfg_data_i[VCNT_W-1:0];
        clear    = 1'b1;
      end else if (cfg_index_i == CFG_DIRECTED_MODE) begin
        directed_d = cfg_data_i[0];
        clear      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= VCOUNT_RST;
      directed_q <= 1'b0;
    end else begin
      vcount_q   <= vcount_d;
      directed_q <= directed_d;
    end
  end

  assign n      = active_n(vcount_q);
  assign n_next = active_n(vcount_d);

  gept_store #(
    .DEG_W(DEG_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .req_i   (req),
    .wr_deg_i(wr_deg),
    .row_o   (row),
    .deg_a_o (deg_a),
    .deg_b_o (deg_b)
  );

  gept_ctrl #(
    .DEG_W          (DEG_W),
    .MAX_LIST_DEGREE(MAX_LIST_DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .src_i      (s_axis_tdata[VTX_W-1:0]),
    .dst_i      (s_axis_tdata[2*VTX_W-1:VTX_W]),
    .n_i        (n),
    .undir_i    (!directed_q),
    .clear_i    (clear),
    .clr_one_i  (n_next == CNT_W'(1)),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .req_o      (req),
    .wr_deg_o   (wr_deg),
    .row_i      (row),
    .deg_a_i    (deg_a),
    .deg_b_i    (deg_b)
  );

  // result word
  always_comb begin
    iso   = ISO_W'(n - res.nonzero);
    pairs = (2*CNT_W)'(n) * (2*CNT_W)'(n - CNT_W'(1));
    cbm   = ((2*CNT_W)'(res.offdiag) == pairs);
    cbd   = (res.full == n);
  end

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
      m_data_d  = {3'b000, cbd, cbm, res.loop_seen, iso, res.status};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== hdl/gept_rmw.sv =====
// Shared update unit: sets one matrix bit and grows one list degree.
`default_nettype none

module gept_rmw import gept_pkg::*; #(
  parameter int DEG_W = 8
) (
  input  logic [MAX_VERTICES-1:0] row_i,
  input  logic [VTX_W-1:0]        col_i,
  input  logic                    diag_i,
  input  logic [DEG_W-1:0]        deg_i,
  input  logic [CNT_W-1:0]        n_i,
  output logic [MAX_VERTICES-1:0] row_o,
  output logic [DEG_W-1:0]        deg_o,
  output cnt_delta_t              delta_o
);

  localparam int CW = ((DEG_W > CNT_W) ? DEG_W : CNT_W) + 1;

  logic [CW-1:0] d_ext;
  logic [CW-1:0] d_inc;
  logic [CW-1:0] nm1;

  always_comb begin
    d_ext = CW'(deg_i);
    d_inc = d_ext + CW'(1);
    nm1   = CW'(n_i) - CW'(1);

    row_o         = row_i;
    row_o[col_i]  = 1'b1;
    deg_o         = d_inc[DEG_W-1:0];

    delta_o.offdiag_inc = !row_i[col_i] && !diag_i;
    delta_o.nonzero_inc = (deg_i == '0);
    delta_o.full_dec    = (d_ext == nm1);
    delta_o.full_inc    = (d_inc == nm1);
  end

endmodule

`default_nettype wire

// ===== hdl/gept_store.sv =====
// Adjacency row memory and list degree memory with per-row valid bits.
`default_nettype none

module gept_store import gept_pkg::*; #(
  parameter int DEG_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  store_req_t              req_i,
  input  logic [DEG_W-1:0]        wr_deg_i,
  output logic [MAX_VERTICES-1:0] row_o,
  output logic [DEG_W-1:0]        deg_a_o,
  output logic [DEG_W-1:0]        deg_b_o
);

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] vld_q, vld_d;
  logic [MAX_VERTICES-1:0] row_raw_q;
  logic [DEG_W-1:0]        deg_a_raw_q, deg_b_raw_q;
  logic                    a_vld_q, b_vld_q;

  // row and degree of a vertex are written together, so one valid bit covers both
  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = '0;
    end else if (req_i.wr_en) begin
      vld_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.rd_en) begin
        a_vld_q <= vld_q[req_i.rd_a];
        b_vld_q <= vld_q[req_i.rd_b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      adj_mem[req_i.wr_addr] <= req_i.wr_row;
      deg_mem[req_i.wr_addr] <= wr_deg_i;
    end
    if (req_i.rd_en) begin
      row_raw_q   <= adj_mem[req_i.rd_a];
      deg_a_raw_q <= deg_mem[req_i.rd_a];
      deg_b_raw_q <= deg_mem[req_i.rd_b];
    end
  end

  assign row_o   = a_vld_q ? row_raw_q : '0;
  assign deg_a_o = a_vld_q ? deg_a_raw_q : '0;
  assign deg_b_o = b_vld_q ? deg_b_raw_q : '0;

endmodule

`default_nettype wire

// ===== hdl/gept_ctrl.sv =====
// Sequencer: edge check, forward and reverse update passes, property counters.
`default_nettype none

module gept_ctrl import gept_pkg::*; #(
  parameter int DEG_W           = 8,
  parameter int MAX_LIST_DEGREE = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [VTX_W-1:0]        src_i,
  input  logic [VTX_W-1:0]        dst_i,
  input  logic [CNT_W-1:0]        n_i,
  input  logic                    undir_i,
  input  logic                    clear_i,
  input  logic                    clr_one_i,
  input  logic                    out_free_i,
  output logic                    res_valid_o,
  output result_t                 res_o,
  output store_req_t              req_o,
  output logic [DEG_W-1:0]        wr_deg_o,
  input  logic [MAX_VERTICES-1:0] row_i,
  input  logic [DEG_W-1:0]        deg_a_i,
  input  logic [DEG_W-1:0]        deg_b_i
);

  localparam int CW = ((DEG_W > CNT_W) ? DEG_W : CNT_W) + 2;

  state_e            state_q, state_d;
  logic [VTX_W-1:0]  src_q, src_d, dst_q, dst_d;
  status_e           status_q, status_d, chk;
  logic [CNT_W-1:0]  nonzero_q, nonzero_d;
  logic [CNT_W-1:0]  full_q, full_d;
  logic [EDGE_W-1:0] offdiag_q, offdiag_d;
  logic              loop_q, loop_d;

  logic [MAX_VERTICES-1:0] row_new;
  logic [DEG_W-1:0]        deg_new;
  cnt_delta_t              delta;
  logic                    same_vtx;

  assign same_vtx = (src_q == dst_q);

  gept_rmw #(
    .DEG_W(DEG_W)
  ) u_rmw (
    .row_i  (row_i),
    .col_i  ((state_q == S_RMOD) ? src_q : dst_q),
    .diag_i (same_vtx),
    .deg_i  (deg_a_i),
    .n_i    (n_i),
    .row_o  (row_new),
    .deg_o  (deg_new),
    .delta_o(delta)
  );

  // edge check on the degrees read at acceptance
  always_comb begin
    if ((CNT_W'(src_q) >= n_i) || (CNT_W'(dst_q) >= n_i)) begin
      chk = ST_RANGE;
    end else if (undir_i && same_vtx) begin
      chk = ((CW'(deg_a_i) + CW'(2)) > CW'(MAX_LIST_DEGREE)) ? ST_FULL : ST_OK;
    end else if ((CW'(deg_a_i) >= CW'(MAX_LIST_DEGREE)) ||
                 (undir_i && (CW'(deg_b_i) >= CW'(MAX_LIST_DEGREE)))) begin
      chk = ST_FULL;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    dst_d       = dst_q;
    status_d    = status_q;
    nonzero_d   = nonzero_q;
    full_d      = full_q;
    offdiag_d   = offdiag_q;
    loop_d      = loop_q;
    res_valid_o = 1'b0;
    in_ready_o  = (state_q == S_IDLE);

    req_o.rd_en   = 1'b0;
    req_o.rd_a    = src_q;
    req_o.rd_b    = dst_q;
    req_o.wr_en   = 1'b0;
    req_o.wr_addr = src_q;
    req_o.wr_row  = row_new;
    wr_deg_o      = deg_new;

    unique case (state_q)
      S_IDLE: begin
        req_o.rd_a  = src_i;
        req_o.rd_b  = dst_i;
        req_o.rd_en = in_valid_i;
        if (in_valid_i) begin
          src_d   = src_i;
          dst_d   = dst_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d = chk;
        if (chk == ST_OK) begin
          req_o.wr_en = 1'b1;
          nonzero_d   = nonzero_q + CNT_W'(delta.nonzero_inc);
          full_d      = full_q + CNT_W'(delta.full_inc) - CNT_W'(delta.full_dec);
          offdiag_d   = offdiag_q + EDGE_W'(delta.offdiag_inc);
          if (same_vtx) begin
            loop_d = 1'b1;
          end
          state_d = undir_i ? S_RREAD : S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RREAD: begin
        // reverse pass rereads after the forward write landed
        req_o.rd_en = 1'b1;
        req_o.rd_a  = dst_q;
        state_d     = S_RMOD;
      end
      S_RMOD: begin
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = dst_q;
        nonzero_d     = nonzero_q + CNT_W'(delta.nonzero_inc);
        full_d        = full_q + CNT_W'(delta.full_inc) - CNT_W'(delta.full_dec);
        offdiag_d     = offdiag_q + EDGE_W'(delta.offdiag_inc);
        state_d       = S_DONE;
      end
      S_DONE: begin
        res_valid_o = out_free_i;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clear_i) begin
      nonzero_d = '0;
      offdiag_d = '0;
      full_d    = clr_one_i ? CNT_W'(1) : '0;
      loop_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= ST_OK;
      nonzero_q <= '0;
      offdiag_q <= '0;
      full_q    <= CNT_W'(MAX_VERTICES == 1);
      loop_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      nonzero_q <= nonzero_d;
      offdiag_q <= offdiag_d;
      full_q    <= full_d;
      loop_q    <= loop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
  end

  always_comb begin
    res_o.status    = status_q;
    res_o.nonzero   = nonzero_q;
    res_o.offdiag   = offdiag_q;
    res_o.full      = full_q;
    res_o.loop_seen = loop_q;
  end

endmodule

`default_nettype wire

// ===== hdl/gept_checker.sv =====
// Port-level checks on the graph edge property tracker, bound to the top level.
`default_nettype none

module gept_checker import gept_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // after taking an edge the sequencer stays busy through its check state and the state that follows
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("edge accepted while previous edge in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b11))
    else $error("undefined status code");

  a_iso_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tdata[ISO_W+1:2]) <= MAX_VERTICES))
    else $error("isolated count above vertex limit");

endmodule

bind graph_edge_property_tracker_unit gept_checker u_gept_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// ===== verif/graph_edge_property_tracker_unit_test.sv =====
// Self-checking testbench for the graph edge property tracker: edge stream in, property words out.
`timescale 1ns / 100ps

module graph_edge_property_tracker_unit_test;
  import gept_pkg::*;

  localparam int LIST_CAP    = 128;
  localparam int STALL_LIMIT = 2000;
  localparam int EDGE_TARGET = 1000;

  // indexes past the register list, ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSVD_3 = 2'd3;

  typedef struct packed {
    status_e    status;
    logic [7:0] isolated;
    logic       loop_seen;
    logic       complete_m;
    logic       complete_d;
  } graph_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  graph_edge_property_tracker_unit #(
    .MAX_LIST_DEGREE(LIST_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // graph tracked on the testbench side
  bit          link_bit [MAX_VERTICES][MAX_VERTICES];
  int unsigned edge_deg [MAX_VERTICES];
  int unsigned touched_cnt, link_cnt, saturated_cnt;
  bit          loop_seen_q;
  logic [7:0]  nv_reg;
  bit          dir_reg;

  logic [IN_TDATA_W-1:0] pending_edges [$];
  graph_report_t         predicted_reports [$];

  int unsigned edges_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned range_rejects = 0, full_rejects = 0, matrix_full = 0, degree_full = 0;
  int unsigned src_gap = 0, sink_hold = 0, quiet_cycles = 0;
  bit          idle_on = 1'b1;
  bit          edge_taken = 1'b0;

  function automatic int unsigned graph_size();
    if (nv_reg == 8'd0) return 1;
    if (nv_reg > 8'(MAX_VERTICES)) return MAX_VERTICES;
    return 32'(nv_reg);
  endfunction

  function automatic void reset_graph();
    foreach (link_bit[r, c]) link_bit[r][c] = 1'b0;
    foreach (edge_deg[i]) edge_deg[i] = 0;
    touched_cnt   = 0;
    link_cnt      = 0;
    saturated_cnt = (graph_size() == 1) ? 1 : 0;
    loop_seen_q   = 1'b0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_VERTEX_COUNT) begin
      nv_reg = val;
    end else if (idx == CFG_DIRECTED_MODE) begin
      dir_reg = val[0];
    end else begin
      return;
    end
    reset_graph();
  endfunction

  function automatic void set_link(input int unsigned r, input int unsigned c);
    if (!link_bit[r][c]) begin
      link_bit[r][c] = 1'b1;
      if (r != c) link_cnt++;
    end
  endfunction

  function automatic void bump_degree(input int unsigned x, input int unsigned n);
    if (edge_deg[x] == 0) touched_cnt++;
    if (edge_deg[x] == n - 1) saturated_cnt--;
    edge_deg[x]++;
    if (edge_deg[x] == n - 1) saturated_cnt++;
  endfunction

  function automatic graph_report_t add_edge(input int unsigned u, input int unsigned v);
    int unsigned   n;
    bit            undirected;
    graph_report_t r;
    n          = graph_size();
    undirected = !dir_reg;
    r.status   = ST_OK;
    if (u >= n || v >= n) begin
      r.status = ST_RANGE;
    end else if (undirected && u == v) begin
      // undirected self-loop lands twice on one list
      if (edge_deg[u] + 2 > LIST_CAP) r.status = ST_FULL;
    end else if (edge_deg[u] >= LIST_CAP || (undirected && edge_deg[v] >= LIST_CAP)) begin
      r.status = ST_FULL;
    end
    if (r.status == ST_OK) begin
      set_link(u, v);
      bump_degree(u, n);
      if (undirected) begin
        set_link(v, u);
        bump_degree(v, n);
      end
      if (u == v) loop_seen_q = 1'b1;
    end
    r.isolated   = 8'(n - touched_cnt);
    r.loop_seen  = loop_seen_q;
    r.complete_m = (link_cnt == n * (n - 1));
    r.complete_d = (saturated_cnt == n);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned rand_vertex(input int unsigned n);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch %0d at word %0d: %s got %0d want %0d",
               mismatches, results_seen, what, got, want);
  endtask

  task automatic queue_edge(input int unsigned u, input int unsigned v);
    pending_edges.push_back({2'b00, VTX_W'(v), VTX_W'(u)});
    edges_queued++;
  endtask

  // blocks until every queued edge has come back as a word
  task automatic wait_drained();
    do @(negedge clk_i); while (results_seen < edges_queued);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    apply_reg_write(idx, val);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // edge driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || edge_taken) begin
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_edges.size() != 0) begin
        s_axis_tdata  <= pending_edges.pop_front();
        s_axis_tvalid <= 1'b1;
        src_gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) sink_hold = pick_gap();
    end
  end

  // monitor: predict on edge accept, check on word accept
  always @(posedge clk_i) begin
    graph_report_t want;
    logic [OUT_TDATA_W-1:0] w;
    edge_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      w = m_axis_tdata;
      if (predicted_reports.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(w), 0);
      end else begin
        want = predicted_reports.pop_front();
        if (w[1:0] != want.status)
          report_mismatch("status", 32'(w[1:0]), 32'(want.status));
        if (w[9:2] != want.isolated)
          report_mismatch("isolated_count", 32'(w[9:2]), 32'(want.isolated));
        if (w[10] != want.loop_seen)
          report_mismatch("self_loop_seen", 32'(w[10]), 32'(want.loop_seen));
        if (w[11] != want.complete_m)
          report_mismatch("complete_by_matrix", 32'(w[11]), 32'(want.complete_m));
        if (w[12] != want.complete_d)
          report_mismatch("complete_by_degree", 32'(w[12]), 32'(want.complete_d));
      end
      results_seen++;
    end
    if (edge_taken) begin
      want = add_edge(32'(s_axis_tdata[VTX_W-1:0]), 32'(s_axis_tdata[2*VTX_W-1:VTX_W]));
      predicted_reports.push_back(want);
      if (want.status == ST_RANGE) range_rejects++;
      if (want.status == ST_FULL) full_rejects++;
      if (want.complete_m) matrix_full++;
      if (want.complete_d) degree_full++;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase_no, n, cnt, h, style;
    logic [7:0]  nv;
    bit          dir;
    nv_reg  = VCOUNT_RST;
    dir_reg = 1'b0;
    reset_graph();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: 128 vertices, undirected; corners, loops, a duplicate
    queue_edge(0, 0);
    queue_edge(127, 127);
    queue_edge(0, 127);
    queue_edge(127, 0);
    queue_edge(5, 9);
    queue_edge(5, 9);
    wait_drained();
    // writes past the register list must leave the graph alone
    cfg_write(CFG_RSVD_2, 8'hff);
    cfg_write(CFG_RSVD_3, 8'h00);
    queue_edge(1, 2);
    wait_drained();
    // triangle: complete both ways, then out of range, then a loop
    cfg_write(CFG_VERTEX_COUNT, 8'd3);
    cfg_write(CFG_DIRECTED_MODE, 8'd0);
    queue_edge(0, 1);
    queue_edge(2, 1);
    queue_edge(0, 2);
    queue_edge(0, 3);
    queue_edge(3, 0);
    queue_edge(2, 2);
    wait_drained();
    cfg_write(CFG_DIRECTED_MODE, 8'd1);
    cfg_write(CFG_VERTEX_COUNT, 8'd2);
    queue_edge(0, 1);
    queue_edge(1, 0);
    queue_edge(1, 1);
    wait_drained();
    // zero vertices behaves as one
    cfg_write(CFG_VERTEX_COUNT, 8'd0);
    queue_edge(0, 0);
    queue_edge(1, 0);
    queue_edge(0, 127);
    wait_drained();
    // oversize count clamps to the maximum
    cfg_write(CFG_VERTEX_COUNT, 8'd255);
    cfg_write(CFG_DIRECTED_MODE, 8'd0);
    queue_edge(127, 126);
    queue_edge(127, 127);
    wait_drained();
    cfg_write(CFG_VERTEX_COUNT, 8'd1);
    queue_edge(0, 0);
    queue_edge(0, 1);
    wait_drained();

    phase_no = 0;
    while (edges_queued < EDGE_TARGET) begin
      case ($urandom_range(0, 9))
        6:       nv = 8'($urandom_range(0, 1));
        7:       nv = 8'd128;
        8:       nv = 8'($urandom_range(129, 255));
        9:       nv = 8'($urandom_range(13, 127));
        default: nv = 8'($urandom_range(2, 12));
      endcase
      dir = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0)
        cfg_write(($urandom_range(0, 1) != 0) ? CFG_RSVD_2 : CFG_RSVD_3, 8'($urandom));
      if ($urandom_range(0, 1) != 0) begin
        cfg_write(CFG_VERTEX_COUNT, nv);
        cfg_write(CFG_DIRECTED_MODE, {7'($urandom), dir});
      end else begin
        cfg_write(CFG_DIRECTED_MODE, {7'($urandom), dir});
        cfg_write(CFG_VERTEX_COUNT, nv);
      end
      n       = graph_size();
      idle_on = ($urandom_range(0, 3) != 0);
      style   = (phase_no == 0) ? 0 : $urandom_range(0, 3);
      if (style == 2 && n > 12) style = 0;
      case (style)
        2: begin
          // every pair once, so both completeness flags come up
          for (int u = 0; u < n; u++) begin
            for (int v = 0; v < n; v++) begin
              if (u != v && (dir || u < v)) begin
                if (!dir && $urandom_range(0, 1) != 0) queue_edge(v, u);
                else queue_edge(u, v);
              end
            end
          end
          repeat (5) queue_edge(rand_vertex(n), rand_vertex(n));
        end
        3: begin
          // pile edges on one vertex until its list runs full
          h = rand_vertex(n);
          for (int i = 0; i < 135; i++)
            queue_edge(h, ($urandom_range(0, 3) == 0) ? h : rand_vertex(n));
        end
        default: begin
          cnt = $urandom_range(30, 120);
          for (int i = 0; i < cnt; i++) begin
            // halfway the sender holds off until all words are back
            if (i == cnt / 2) wait_drained();
            if ($urandom_range(0, 9) == 0)
              queue_edge($urandom_range(0, 127), $urandom_range(0, 127));
            else
              queue_edge(rand_vertex(n), rand_vertex(n));
          end
        end
      endcase
      wait_drained();
      phase_no++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("%0d edges over %0d register writes, %0d out of range, %0d on full lists",
             edges_queued, cfg_writes, range_rejects, full_rejects);
    $display("complete graph seen %0d times by matrix and %0d times by degree",
             matrix_full, degree_full);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gept_pkg.sv
hdl/gept_rmw.sv
hdl/gept_store.sv
hdl/gept_ctrl.sv
hdl/graph_edge_property_tracker_unit.sv
hdl/gept_checker.sv
verif/graph_edge_property_tracker_unit_test.sv
